// ===== rtl/clr_pkg.sv =====
// ----------------------------------------------------------------------------
// clr_pkg
// Shared types and constants for the clipped line rasterizer.
// ----------------------------------------------------------------------------
package clr_pkg;

    // Command codes on the request channel
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_CLIP_MAX_X = 2'd0;
    localparam logic [1:0] REG_CLIP_MAX_Y = 2'd1;

    // Outcode bits
    localparam logic [3:0] OC_LEFT   = 4'd1;
    localparam logic [3:0] OC_RIGHT  = 4'd2;
    localparam logic [3:0] OC_BOTTOM = 4'd4;
    localparam logic [3:0] OC_TOP    = 4'd8;

    // Clip rounds before a segment is given up
    localparam logic [3:0] CLIP_ROUNDS = 4'd8;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_PIXEL  = 2'd2,
        KIND_IDLE   = 2'd3
    } kind_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_SUM,
        ST_DIV_GO,
        ST_DIV_WAIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // latch a new segment
        logic step;     // produce one step result
        logic setup;    // pick edge and latch crossing operands
        logic mul;      // register both products
        logic sum;      // register the numerator
        logic div_go;   // start the divider
        logic upd;      // write the clipped point back
        logic accept;   // set up stepping, post accept result
        logic reject;   // post reject result
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
        logic in_rect;
        logic reject;
        logic div_done;
    } dp_sts_t;

endpackage

// ===== rtl/clr_div.sv =====
// ----------------------------------------------------------------------------
// clr_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module clr_div #(
    parameter int N = 34,
    parameter int D = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic [N-1:0] quotient,
    output logic         done
);
    localparam int CNTW = $clog2(N + 1);

    logic [D-1:0]    rem_reg;
    logic [N-1:0]    quo_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [D:0]      trial;
    logic            fits;

    // One shift-and-subtract step
    assign trial = {rem_reg, quo_reg[N-1]};
    assign fits  = (trial >= {1'b0, divisor});

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNTW'(N);
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNTW'(1));
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // Remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? D'(trial - {1'b0, divisor}) : trial[D-1:0];
            quo_reg <= {quo_reg[N-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/clr_dp.sv =====
// ----------------------------------------------------------------------------
// clr_dp
// Datapath: clip registers, crossing arithmetic, Bresenham state, result reg.
// ----------------------------------------------------------------------------
module clr_dp #(
    parameter int COORD_BITS  = 16,
    parameter int SCREEN_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [1:0]                    cfg_index,
    input  logic [SCREEN_BITS-1:0]        cfg_data,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    input  logic [31:0]                   line_color,
    input  clr_pkg::dp_cmd_t              ctl,
    output clr_pkg::dp_sts_t              sts,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [1:0]                    kind,
    output logic [SCREEN_BITS-1:0]        pixel_x,
    output logic [SCREEN_BITS-1:0]        pixel_y,
    output logic [31:0]                   pixel_color,
    output logic                          last_pixel
);
    import clr_pkg::*;

    localparam int SB = SCREEN_BITS;
    localparam int CW = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS + 1;
    localparam int PW = 2 * CW + 2;
    localparam int EW = SCREEN_BITS + 3;

    // Clip bounds
    logic [SB-1:0] max_x_reg, max_y_reg;

    // Clipping state
    logic signed [CW-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [3:0]           round_reg;
    logic [31:0]          color_reg;

    // Crossing operands
    logic signed [CW-1:0] a0_reg;
    logic signed [CW:0]   da_reg, eb_reg, dd_reg;
    logic                 dz_reg, mv0_reg, horiz_reg;
    logic [SB-1:0]        edge_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, t_reg;

    // Bresenham state
    logic                 active_reg;
    logic [SB-1:0]        cur_x_reg, cur_y_reg, stop_x_reg, stop_y_reg;
    logic [SB-1:0]        dx_reg;
    logic signed [SB:0]   ndy_reg;
    logic                 sxn_reg, syn_reg;
    logic signed [EW-1:0] err_reg;

    // Result register
    logic                 out_valid_reg;
    kind_t                kind_reg;
    logic [SB-1:0]        px_reg, py_reg;
    logic [31:0]          pc_reg;
    logic                 last_reg;

    function automatic logic [3:0] outc(input logic signed [CW-1:0] x,
                                        input logic signed [CW-1:0] y,
                                        input logic [SB-1:0] mx,
                                        input logic [SB-1:0] my);
        logic [3:0] c;
        c = 4'd0;
        if (x < 0)
            c = c | OC_LEFT;
        else if (x > $signed(CW'(mx)))
            c = c | OC_RIGHT;
        if (y < 0)
            c = c | OC_BOTTOM;
        else if (y > $signed(CW'(my)))
            c = c | OC_TOP;
        return c;
    endfunction

    // Outcodes and edge selection
    logic [3:0]           c0, c1, co;
    logic                 horiz, dneg;
    logic [SB-1:0]        edge_u;
    logic signed [CW:0]   edge_w, a0e, a1e, b0e, b1e, dd, da, eb, ddabs;

    always_comb
    begin
        c0    = outc(x0_reg, y0_reg, max_x_reg, max_y_reg);
        c1    = outc(x1_reg, y1_reg, max_x_reg, max_y_reg);
        co    = (c0 != 4'd0) ? c0 : c1;
        horiz = ((co & (OC_TOP | OC_BOTTOM)) != 4'd0);
        if ((co & OC_TOP) != 4'd0)
            edge_u = max_y_reg;
        else if ((co & OC_BOTTOM) != 4'd0)
            edge_u = '0;
        else if ((co & OC_RIGHT) != 4'd0)
            edge_u = max_x_reg;
        else
            edge_u = '0;
        edge_w = $signed((CW + 1)'(edge_u));
        a0e    = horiz ? (CW + 1)'(x0_reg) : (CW + 1)'(y0_reg);
        a1e    = horiz ? (CW + 1)'(x1_reg) : (CW + 1)'(y1_reg);
        b0e    = horiz ? (CW + 1)'(y0_reg) : (CW + 1)'(x0_reg);
        b1e    = horiz ? (CW + 1)'(y1_reg) : (CW + 1)'(x1_reg);
        da     = a1e - a0e;
        dd     = b1e - b0e;
        dneg   = dd[CW];
        ddabs  = dneg ? -dd : dd;
        eb     = dneg ? (b0e - edge_w) : (edge_w - b0e);
    end

    assign sts.in_rect  = ((c0 | c1) == 4'd0);
    assign sts.reject   = ((c0 & c1) != 4'd0) || (round_reg == CLIP_ROUNDS);
    assign sts.out_free = !out_valid_reg || out_ready;

    // Divider for the crossing
    logic [PW-1:0] quo;
    logic [PW-1:0] t_abs;

    assign t_abs = t_reg[PW-1] ? PW'(-t_reg) : PW'(t_reg);

    clr_div #(
        .N (PW),
        .D (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_go),
        .dividend (t_abs),
        .divisor  (dd_reg[CW-1:0]),
        .quotient (quo),
        .done     (sts.div_done)
    );

    // Crossing value, truncated toward zero
    logic [CW-1:0]        q_mag;
    logic signed [CW-1:0] cross_val, edge_c;

    assign q_mag     = quo[CW-1:0];
    assign cross_val = dz_reg ? a0_reg
                     : (t_reg[PW-1] ? $signed(~q_mag + CW'(1)) : $signed(q_mag));
    assign edge_c    = $signed(CW'(edge_reg));

    // Stepping setup from the accepted segment
    logic [SB-1:0]        sx0, sy0, sx1, sy1, adx, ady;
    logic signed [SB:0]   ndy_new;

    always_comb
    begin
        sx0     = x0_reg[SB-1:0];
        sy0     = y0_reg[SB-1:0];
        sx1     = x1_reg[SB-1:0];
        sy1     = y1_reg[SB-1:0];
        adx     = (sx1 >= sx0) ? (sx1 - sx0) : (sx0 - sx1);
        ady     = (sy1 >= sy0) ? (sy1 - sy0) : (sy0 - sy1);
        ndy_new = -$signed((SB + 1)'(ady));
    end

    // Bresenham step
    logic signed [EW:0]   e2, ndy_e, dx_e;
    logic                 go_x, go_y, at_end;
    logic signed [EW-1:0] err_step;

    always_comb
    begin
        e2       = {err_reg, 1'b0};
        ndy_e    = (EW + 1)'(ndy_reg);
        dx_e     = $signed((EW + 1)'(dx_reg));
        go_x     = (e2 >= ndy_e);
        go_y     = (e2 <= dx_e);
        at_end   = (cur_x_reg == stop_x_reg) && (cur_y_reg == stop_y_reg);
        err_step = err_reg + (go_x ? EW'(ndy_reg) : EW'(0))
                           + (go_y ? $signed(EW'(dx_reg)) : EW'(0));
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= SB'(639);
            max_y_reg <= SB'(479);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CLIP_MAX_X: max_x_reg <= cfg_data;
                REG_CLIP_MAX_Y: max_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control flops: line active, round count, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load)
                round_reg <= '0;
            else if (ctl.upd)
                round_reg <= round_reg + 4'd1;

            if (ctl.load || ctl.reject)
                active_reg <= 1'b0;
            else if (ctl.accept)
                active_reg <= 1'b1;
            else if (ctl.step && active_reg && at_end)
                active_reg <= 1'b0;

            if (ctl.accept || ctl.reject || ctl.step)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload flops
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x0_reg    <= CW'(start_x);
            y0_reg    <= CW'(start_y);
            x1_reg    <= CW'(end_x);
            y1_reg    <= CW'(end_y);
            color_reg <= line_color;
        end
        if (ctl.setup)
        begin
            a0_reg    <= a0e[CW-1:0];
            da_reg    <= da;
            eb_reg    <= eb;
            dd_reg    <= ddabs;
            dz_reg    <= (dd == 0);
            mv0_reg   <= (c0 != 4'd0);
            horiz_reg <= horiz;
            edge_reg  <= edge_u;
        end
        if (ctl.mul)
        begin
            p1_reg <= (CW + 1)'(a0_reg) * dd_reg;
            p2_reg <= da_reg * eb_reg;
        end
        if (ctl.sum)
            t_reg <= p1_reg + p2_reg;
        // Move the outside point onto the clip edge
        if (ctl.upd)
        begin
            if (mv0_reg)
            begin
                x0_reg <= horiz_reg ? cross_val : edge_c;
                y0_reg <= horiz_reg ? edge_c : cross_val;
            end
            else
            begin
                x1_reg <= horiz_reg ? cross_val : edge_c;
                y1_reg <= horiz_reg ? edge_c : cross_val;
            end
        end
        if (ctl.accept)
        begin
            cur_x_reg  <= sx0;
            cur_y_reg  <= sy0;
            stop_x_reg <= sx1;
            stop_y_reg <= sy1;
            dx_reg     <= adx;
            ndy_reg    <= ndy_new;
            sxn_reg    <= !(sx0 < sx1);
            syn_reg    <= !(sy0 < sy1);
            err_reg    <= $signed(EW'(adx)) + EW'(ndy_new);
        end
        else if (ctl.step && active_reg && !at_end)
        begin
            err_reg <= err_step;
            if (go_x)
                cur_x_reg <= sxn_reg ? (cur_x_reg - SB'(1)) : (cur_x_reg + SB'(1));
            if (go_y)
                cur_y_reg <= syn_reg ? (cur_y_reg - SB'(1)) : (cur_y_reg + SB'(1));
        end

        // Result register
        if (ctl.accept || ctl.reject || (ctl.step && !active_reg))
        begin
            kind_reg <= ctl.accept ? KIND_ACCEPT : (ctl.reject ? KIND_REJECT : KIND_IDLE);
            px_reg   <= '0;
            py_reg   <= '0;
            pc_reg   <= '0;
            last_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            kind_reg <= KIND_PIXEL;
            px_reg   <= cur_x_reg;
            py_reg   <= cur_y_reg;
            pc_reg   <= color_reg;
            last_reg <= at_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_color = pc_reg;
    assign last_pixel  = last_reg;

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(ctl.accept || ctl.reject || ctl.step))
        else $error("result register overwritten while held");

    // Round count stays within its bound
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= CLIP_ROUNDS)
        else $error("clip round count out of range");

    // Accepted segment starts inside the clip rectangle
    a_accept_inside: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept |=> (active_reg && cur_x_reg <= max_x_reg && cur_y_reg <= max_y_reg))
        else $error("accepted segment starts outside clip rectangle");

endmodule

// ===== rtl/clr_ctrl.sv =====
// ----------------------------------------------------------------------------
// clr_ctrl
// Sequencer for load clipping rounds and step requests taken in the idle state.
// ----------------------------------------------------------------------------
module clr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              cmd,
    output logic              in_ready,
    output clr_pkg::dp_cmd_t  ctl,
    input  clr_pkg::dp_sts_t  sts
);
    import clr_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = sts.out_free;
                if (in_valid && sts.out_free)
                begin
                    if (cmd == CMD_LOAD)
                    begin
                        ctl.load   = 1'b1;
                        state_next = ST_EVAL;
                    end
                    else
                        ctl.step = 1'b1;
                end
            end
            ST_EVAL:
            begin
                if (sts.in_rect)
                begin
                    ctl.accept = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (sts.reject)
                begin
                    ctl.reject = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctl.setup  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                ctl.sum    = 1'b1;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                ctl.div_go = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    ctl.upd    = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Divider completes only while it is awaited
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider done outside wait state");

    // Clip round always returns to evaluation
    a_upd_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.upd |=> (state_reg == ST_EVAL))
        else $error("clip round did not return to evaluation");

endmodule

// ===== rtl/clipped_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// clipped_line_rasterizer
// Cohen-Sutherland clip of a line request, then Bresenham pixel stepping.
// ----------------------------------------------------------------------------
// A step request (cmd 1) is taken in the idle state when the output is free
// and its pixel, or an idle result, appears in the output register on the
// next edge; steps stream at one per cycle while the consumer keeps up. A
// load request (cmd 0) runs the clipper: an outcode test, then each clip
// round runs operand setup, products, numerator and divider start, and waits
// on the bit-serial divider before the clipped point is written back and the
// outcodes are tested again. Clipping stops after at most eight rounds
// (ordinary segments need four or fewer); no request is taken while a load
// runs. Configuration writes are taken in any cycle.
module clipped_line_rasterizer #(
    parameter int COORD_BITS  = 16,
    parameter int SCREEN_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [SCREEN_BITS-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    input  logic [31:0]                   line_color,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    kind,
    output logic [SCREEN_BITS-1:0]        pixel_x,
    output logic [SCREEN_BITS-1:0]        pixel_y,
    output logic [31:0]                   pixel_color,
    output logic                          last_pixel
);
    import clr_pkg::*;

    dp_cmd_t ctl;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    clr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .in_ready (in_ready),
        .ctl      (ctl),
        .sts      (sts)
    );

    clr_dp #(
        .COORD_BITS  (COORD_BITS),
        .SCREEN_BITS (SCREEN_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .line_color  (line_color),
        .ctl         (ctl),
        .sts         (sts),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .kind        (kind),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

endmodule
